// ===== hdl/dotq_pkg.sv =====
// package for the deadline ordered timer queue
// holds beat structs, status codes, entry type and controller states
package dotq_pkg;

    localparam int DepthDef   = 32;
    localparam int MaxResults = 32;
    localparam int DlW        = 48;
    localparam int TagW       = 32;
    localparam int DelayW     = 32;

    typedef enum logic [1:0] {
        ST_POSTED  = 2'd0,
        ST_FULL    = 2'd1,
        ST_EXPIRED = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef struct packed {
        logic              action;
        logic [DlW-1:0]    now_time;
        logic [DelayW-1:0] delay;
        logic [TagW-1:0]   handle_tag;
    } in_item_t;

    typedef struct packed {
        status_t         status;
        logic [TagW-1:0] out_tag;
        logic [DlW-1:0]  out_deadline;
        logic            last;
    } out_item_t;

    typedef struct packed {
        logic [DlW-1:0]  deadline;
        logic [TagW-1:0] tag;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POST_CMP,
        S_POST_WR,
        S_EXP_CMP,
        S_EMIT
    } state_t;

endpackage

// ===== hdl/dotq_mem.sv =====
// timer entry store: one write port, one registered read port
// depends on dotq_pkg for entry_t
module dotq_mem #(
    parameter int DEPTH = dotq_pkg::DepthDef,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                   clk,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output dotq_pkg::entry_t       rd_data,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  dotq_pkg::entry_t       wr_data
);
    import dotq_pkg::*;

    entry_t store_mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rdata_reg;

endmodule

// ===== hdl/dotq_ctrl.sv =====
// sequencer for the timer queue: sorted insert by walking back from the tail,
// expire by popping from the head of a circular store; depends on dotq_pkg
module dotq_ctrl #(
    parameter int DEPTH = dotq_pkg::DepthDef,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dotq_pkg::in_item_t   in_data,
    output logic                 emit_valid,
    input  logic                 emit_ready,
    output dotq_pkg::out_item_t  emit_item,
    output logic                 rd_en,
    output logic [AW-1:0]        rd_addr,
    input  dotq_pkg::entry_t     rd_data,
    output logic                 wr_en,
    output logic [AW-1:0]        wr_addr,
    output dotq_pkg::entry_t     wr_data
);
    import dotq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = $clog2(MaxResults + 1);

    state_t           state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [NW-1:0]    n_reg, n_next;
    logic             hold_reg, hold_next;
    logic [DlW-1:0]   key_reg, key_next;
    logic [TagW-1:0]  tag_reg, tag_next;
    status_t          em_status_reg, em_status_next;
    logic [TagW-1:0]  em_tag_reg, em_tag_next;
    logic [DlW-1:0]   em_dl_reg, em_dl_next;

    logic [DlW:0]     dl_sum;
    logic [DlW-1:0]   dl_sat;
    logic             due;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [AW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (AW+1)'(DEPTH))
        begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    assign dl_sum = {1'b0, in_data.now_time} + (DlW+1)'(in_data.delay);
    assign dl_sat = dl_sum[DlW] ? '1 : dl_sum[DlW-1:0];
    assign due    = (rd_data.deadline <= key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            pos_reg   <= '0;
            n_reg     <= '0;
            hold_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            n_reg     <= n_next;
            hold_reg  <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        tag_reg       <= tag_next;
        em_status_reg <= em_status_next;
        em_tag_reg    <= em_tag_next;
        em_dl_reg     <= em_dl_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        hold_next      = hold_reg;
        key_next       = key_reg;
        tag_next       = tag_reg;
        em_status_next = em_status_reg;
        em_tag_next    = em_tag_reg;
        em_dl_next     = em_dl_reg;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        wr_en          = 1'b0;
        wr_addr        = head_reg;
        wr_data        = '{deadline: key_reg, tag: tag_reg};
        in_stall       = (state_reg != S_IDLE);
        emit_valid     = 1'b0;
        emit_item      = '{status: em_status_reg, out_tag: em_tag_reg,
                           out_deadline: em_dl_reg, last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    em_tag_next = '0;
                    em_dl_next  = '0;
                    if (!in_data.action)
                    begin
                        key_next = dl_sat;
                        tag_next = in_data.handle_tag;
                        if (count_reg == CW'(DEPTH))
                        begin
                            em_status_next = ST_FULL;
                            state_next     = S_EMIT;
                        end
                        else if (count_reg == '0)
                        begin
                            wr_en          = 1'b1;
                            wr_addr        = head_reg;
                            wr_data        = '{deadline: dl_sat, tag: in_data.handle_tag};
                            count_next     = count_reg + CW'(1);
                            em_status_next = ST_POSTED;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            pos_next   = count_reg[AW-1:0];
                            rd_en      = 1'b1;
                            rd_addr    = phys(head_reg, count_reg[AW-1:0] - AW'(1));
                            state_next = S_POST_CMP;
                        end
                    end
                    else
                    begin
                        key_next  = in_data.now_time;
                        n_next    = '0;
                        hold_next = 1'b0;
                        if (count_reg == '0)
                        begin
                            em_status_next = ST_NONE;
                            state_next     = S_EMIT;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = head_reg;
                            state_next = S_EXP_CMP;
                        end
                    end
                end
            end

            S_POST_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = phys(head_reg, pos_reg);
                if (rd_data.deadline > key_reg)
                begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - AW'(1);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = S_POST_WR;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        rd_addr = phys(head_reg, pos_reg - AW'(2));
                    end
                end
                else
                begin
                    count_next     = count_reg + CW'(1);
                    em_status_next = ST_POSTED;
                    state_next     = S_EMIT;
                end
            end

            S_POST_WR:
            begin
                wr_en          = 1'b1;
                wr_addr        = head_reg;
                count_next     = count_reg + CW'(1);
                em_status_next = ST_POSTED;
                state_next     = S_EMIT;
            end

            S_EXP_CMP:
            begin
                if (!hold_reg || emit_ready)
                begin
                    if (hold_reg)
                    begin
                        emit_valid     = 1'b1;
                        emit_item.last = !due;
                    end
                    if (!due)
                    begin
                        if (hold_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            em_status_next = ST_NONE;
                            state_next     = S_EMIT;
                        end
                    end
                    else
                    begin
                        em_status_next = ST_EXPIRED;
                        em_tag_next    = rd_data.tag;
                        em_dl_next     = rd_data.deadline;
                        hold_next      = 1'b1;
                        head_next      = phys(head_reg, AW'(1));
                        count_next     = count_reg - CW'(1);
                        n_next         = n_reg + NW'(1);
                        if ((n_reg + NW'(1) == NW'(MaxResults)) || (count_reg == CW'(1)))
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            rd_en   = 1'b1;
                            rd_addr = phys(head_reg, AW'(1));
                        end
                    end
                end
            end

            S_EMIT:
            begin
                emit_valid = 1'b1;
                if (emit_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_burst_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= NW'(MaxResults))
        else $error("expire burst above limit");

    a_emit_state: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> (state_reg == S_EMIT) || (state_reg == S_EXP_CMP && hold_reg))
        else $error("beat emitted outside an emitting state");

    a_post_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POST_WR) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the store");
`endif

endmodule

// ===== hdl/deadline_ordered_timer_queue.sv =====
// top level of the deadline ordered timer queue: sequencer, entry store,
// output register; depends on dotq_pkg, dotq_ctrl and dotq_mem
//
//  channel | direction | beat         | handshake
//  in      | input     | in_item_t    | in_valid / in_stall
//  out     | output    | out_item_t   | out_valid / out_stall
//
// a post walks back over each stored timer with a later deadline, one store read each,
// and skips the walk when the store is empty or full
// an expire pops each removed timer from the head, one store read each,
// and reads the head once when none is due in a non-empty store
// the single read port of the entry store serialises these reads
// reset empties the queue at once, no clearing pass
// out_stall holds the output register and, through it, the sequencer
module deadline_ordered_timer_queue #(
    parameter int DEPTH = dotq_pkg::DepthDef
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  dotq_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output dotq_pkg::out_item_t  out_data
);
    import dotq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          emit_valid;
    logic          emit_ready;
    out_item_t     emit_item;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    logic          out_valid_reg, out_valid_next;
    out_item_t     out_data_reg, out_data_next;

    dotq_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .emit_item  (emit_item),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    dotq_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign emit_ready = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (emit_valid && emit_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== dv/testbench.sv =====
// self-checking testbench for the deadline ordered timer queue
// predicts posts, rejects and expiries in a scoreboard class; depends on dotq_pkg
`timescale 1ns / 1ps

module testbench;
    import dotq_pkg::*;

    localparam int Depth = 32;
    localparam logic [47:0] MaxDl = 48'hFFFF_FFFF_FFFF;

    class timer_scoreboard;
        logic [47:0] pend_deadline[$];
        logic [31:0] pend_tag[$];
        out_item_t   awaited[$];
        int          errors;
        int          checked;

        function void note_item(in_item_t it);
            logic [48:0] sum;
            logic [47:0] dl;
            out_item_t   r;
            int          pos;
            int          n;
            sum = {1'b0, it.now_time} + {17'd0, it.delay};
            dl = sum[48] ? MaxDl : sum[47:0];
            r = '0;
            r.last = 1'b1;
            if (it.action == 1'b0) begin
                if (pend_deadline.size() >= Depth) begin
                    r.status = ST_FULL;
                end
                else begin
                    pos = 0;
                    while (pos < pend_deadline.size() && pend_deadline[pos] <= dl)
                        pos++;
                    pend_deadline.insert(pos, dl);
                    pend_tag.insert(pos, it.handle_tag);
                    r.status = ST_POSTED;
                end
                awaited.push_back(r);
            end
            else begin
                n = 0;
                while (n < pend_deadline.size() && n < MaxResults
                       && pend_deadline[n] <= it.now_time)
                    n++;
                if (n == 0) begin
                    r.status = ST_NONE;
                    awaited.push_back(r);
                end
                for (int i = 0; i < n; i++) begin
                    r.status = ST_EXPIRED;
                    r.out_tag = pend_tag[0];
                    r.out_deadline = pend_deadline[0];
                    r.last = (i == n - 1);
                    awaited.push_back(r);
                    void'(pend_deadline.pop_front());
                    void'(pend_tag.pop_front());
                end
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (awaited.size() == 0) begin
                $error("unexpected result status=%0d", got.status);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status) begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.out_tag !== want.out_tag) begin
                $error("out_tag expected %h actual %h", want.out_tag, got.out_tag);
                errors++;
            end
            if (got.out_deadline !== want.out_deadline) begin
                $error("out_deadline expected %h actual %h", want.out_deadline,
                       got.out_deadline);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last expected %0d actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    timer_scoreboard sb;
    logic [47:0] clock_now;
    bit          calm;
    int          hold_cycles;
    int          posts;
    int          expires;

    deadline_ordered_timer_queue #(.DEPTH(Depth)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // receiver side: stall bursts, one long hold on request
    initial
    begin
        int gap;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 13);
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    task automatic send_item(input in_item_t it);
        if (!calm && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_item(it);
        if (it.action) expires++; else posts++;
    endtask

    task automatic post_timer(input logic [47:0] now, input logic [31:0] dly,
                              input logic [31:0] tag);
        in_item_t it;
        it = '0;
        it.action = 1'b0;
        it.now_time = now;
        it.delay = dly;
        it.handle_tag = tag;
        send_item(it);
    endtask

    task automatic expire_at(input logic [47:0] now);
        in_item_t it;
        it.action = 1'b1;
        it.now_time = now;
        it.delay = $urandom();
        it.handle_tag = $urandom();
        send_item(it);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int k;
        sb = new();
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        calm = 1'b0;
        hold_cycles = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty expire, extremes, saturation, ties, full store
        expire_at(48'd0);
        post_timer(48'd0, 32'd0, 32'hFFFF_FFFF);
        post_timer(MaxDl, 32'hFFFF_FFFF, 32'h0);
        post_timer(48'hFFFF_FFFF_0000, 32'hFFFF_FFFF, 32'h5555_AAAA);
        post_timer(48'd100, 32'd5, 32'd1);
        post_timer(48'd104, 32'd1, 32'd2);
        post_timer(48'd50, 32'd55, 32'd3);
        expire_at(48'd104);
        expire_at(48'd105);
        expire_at(MaxDl);
        drain();
        for (k = 0; k < Depth + 2; k++)
            post_timer(48'd10, k[31:0] % 4, 32'hA000 + k);
        drain();
        expire_at(MaxDl);
        drain();

        // long receiver hold while the sender keeps posting
        hold_cycles = 300;
        for (k = 0; k < 20; k++)
            post_timer({16'd0, $urandom()}, $urandom(), $urandom());
        expire_at(MaxDl);
        drain();

        // random: mostly a moving clock with short delays, some raw noise
        clock_now = 48'd1000;
        for (k = 0; k < 143; k++)
        begin
            if (k == 113) begin
                drain();
                calm = 1'b1;
            end
            case ($urandom_range(0, 9))
                0: post_timer(48'({$urandom(), $urandom()}), $urandom(), $urandom());
                1: expire_at(48'({$urandom(), $urandom()}));
                2, 3, 4: begin
                    clock_now += $urandom_range(0, 30);
                    expire_at(clock_now);
                end
                default: post_timer(clock_now, $urandom_range(0, 60), $urandom());
            endcase
        end
        expire_at(MaxDl);
        drain();
        repeat (20) @(posedge clk);
        $display("%0d posts and %0d expire polls sent, %0d results checked",
                 posts, expires, sb.checked);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
